// File: rtl/vnts_pkg.sv
`default_nettype none
package vnts_pkg;

  localparam int unsigned MAX_DIM_DEF   = 4096;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // lattice hash constants
  localparam logic [31:0] HASH_KX  = 32'd374761393;
  localparam logic [31:0] HASH_KY  = 32'd668265263;
  localparam logic [31:0] HASH_KS  = 32'd2246822519;
  localparam logic [31:0] HASH_OFF = 32'h9E3779B9;
  localparam logic [31:0] HASH_MIX = 32'd1274126177;

  localparam logic [17:0] OCT2_MUL = 18'd176947;  // 2.7 in Q2.16
  localparam logic [15:0] MIX_W0   = 16'd45875;   // 0.7 in Q0.16
  localparam logic [15:0] MIX_W1   = 16'd19661;   // 0.3 in Q0.16

  // pipeline depth of the octave and shading units
  localparam int unsigned OCT_LAT   = 6;
  localparam int unsigned SHADE_LAT = 6;

  localparam logic [2:0] CFG_NOISE_SCALE     = 3'd0;
  localparam logic [2:0] CFG_SEED            = 3'd1;
  localparam logic [2:0] CFG_NOISE_STRENGTH  = 3'd2;
  localparam logic [2:0] CFG_GRID_SPACING    = 3'd3;
  localparam logic [2:0] CFG_GRID_LINE_WIDTH = 3'd4;
  localparam logic [2:0] CFG_GRID_DARKEN     = 3'd5;
  localparam logic [2:0] CFG_BASE_COLOR      = 3'd6;
  localparam logic [2:0] CFG_IMAGE_DIMS      = 3'd7;

  typedef struct packed {
    logic [15:0] noise_scale;
    logic [31:0] seed;
    logic [15:0] noise_strength;
    logic [15:0] grid_spacing;
    logic [15:0] grid_line_width;
    logic [15:0] grid_darken;
    logic [23:0] base_color;
    logic [25:0] image_dims;
  } vnts_cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       on_seam;
  } vnts_pix_t;

endpackage
`default_nettype wire

// File: rtl/vnts_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module vnts_div #(
  parameter int unsigned DVW  = 28,
  parameter int unsigned DIMW = 13
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [DVW-1:0]  dividend_i,
  input  wire logic [DIMW-1:0] divisor_i,
  output logic      [DVW-1:0]  quotient_o
);

  logic [DIMW-1:0] rem_q [DVW];
  logic [DVW-1:0]  num_q [DVW];

  for (genvar k = 0; k < DVW; k++) begin : g_stage
    logic [DIMW-1:0] rem_in;
    logic [DVW-1:0]  num_in;
    logic [DIMW:0]   trial;
    logic [DIMW:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
    end

    assign trial = {rem_in, num_in[DVW-1]};
    assign ge    = trial >= {1'b0, divisor_i};
    assign diff  = trial - {1'b0, divisor_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DIMW-1:0] : trial[DIMW-1:0];
        num_q[k] <= {num_in[DVW-2:0], ge};
      end
    end
  end

  assign quotient_o = num_q[DVW-1];

endmodule
`default_nettype wire

// File: rtl/vnts_oct.sv
`default_nettype none
// One octave of value noise: lattice hash, smoothstep, bilinear blend.
module vnts_oct #(
  parameter int unsigned XW        = 36,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [XW-1:0] x_i,
  input  wire logic [XW-1:0] y_i,
  input  wire logic [31:0]   seed_i,
  output logic      [23:0]   noise_o
);

  localparam int unsigned FW = FRAC_BITS + 16;

  // stage 1: corner products and squares of the fractions
  logic [31:0] ix, iy;
  logic [FW-1:0] fx, fy;
  logic [15:0] tx, ty;
  logic [31:0] pa_q, pb_q, pc_q, sqx_q, sqy_q;
  logic [15:0] tx_q, ty_q;

  assign ix = 32'(x_i >> FRAC_BITS);
  assign iy = 32'(y_i >> FRAC_BITS);
  assign fx = {x_i[FRAC_BITS-1:0], 16'b0} >> FRAC_BITS;
  assign fy = {y_i[FRAC_BITS-1:0], 16'b0} >> FRAC_BITS;
  assign tx = fx[15:0];
  assign ty = fy[15:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q  <= ix * vnts_pkg::HASH_KX;
      pb_q  <= iy * vnts_pkg::HASH_KY;
      pc_q  <= seed_i * vnts_pkg::HASH_KS;
      sqx_q <= 32'(tx) * 32'(tx);
      sqy_q <= 32'(ty) * 32'(ty);
      tx_q  <= tx;
      ty_q  <= ty;
    end
  end

  // stage 2: corner sums, first xor-shift, smoothstep
  logic [31:0] h00, h10, h01, h11;
  logic [31:0] hs_q [4];
  logic [17:0] kx, ky;
  logic [49:0] smx, smy;
  logic [15:0] sx_q, sy_q;

  assign h00 = pa_q + pb_q + pc_q + vnts_pkg::HASH_OFF;
  assign h10 = h00 + vnts_pkg::HASH_KX;
  assign h01 = h00 + vnts_pkg::HASH_KY;
  assign h11 = h00 + vnts_pkg::HASH_KX + vnts_pkg::HASH_KY;
  assign kx  = 18'd196608 - {1'b0, tx_q, 1'b0};
  assign ky  = 18'd196608 - {1'b0, ty_q, 1'b0};
  assign smx = 50'(sqx_q) * 50'(kx);
  assign smy = 50'(sqy_q) * 50'(ky);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hs_q[0] <= h00 ^ (h00 >> 13);
      hs_q[1] <= h10 ^ (h10 >> 13);
      hs_q[2] <= h01 ^ (h01 >> 13);
      hs_q[3] <= h11 ^ (h11 >> 13);
      sx_q    <= smx[47:32];
      sy_q    <= smy[47:32];
    end
  end

  // stage 3: mixing multiply
  logic [31:0] hm_q [4];
  logic [15:0] sx2_q, sy2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        hm_q[i] <= hs_q[i] * vnts_pkg::HASH_MIX;
      end
      sx2_q <= sx_q;
      sy2_q <= sy_q;
    end
  end

  // stage 4: corner values
  logic [23:0] cv_q [4];
  logic [15:0] sx3_q, sy3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        cv_q[i] <= 24'(hm_q[i] ^ (hm_q[i] >> 16));
      end
      sx3_q <= sx2_q;
      sy3_q <= sy2_q;
    end
  end

  // stage 5: blend along x
  logic [16:0] wx, wy;
  logic [41:0] top_s, bot_s;
  logic [23:0] top_q, bot_q;
  logic [15:0] sy4_q;

  assign wx    = 17'd65536 - {1'b0, sx3_q};
  assign top_s = 42'(cv_q[0]) * 42'(wx) + 42'(cv_q[1]) * 42'(sx3_q);
  assign bot_s = 42'(cv_q[2]) * 42'(wx) + 42'(cv_q[3]) * 42'(sx3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_q <= top_s[39:16];
      bot_q <= bot_s[39:16];
      sy4_q <= sy3_q;
    end
  end

  // stage 6: blend along y
  logic [41:0] fin_s;
  logic [23:0] noise_q;

  assign wy    = 17'd65536 - {1'b0, sy4_q};
  assign fin_s = 42'(top_q) * 42'(wy) + 42'(bot_q) * 42'(sy4_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      noise_q <= fin_s[39:16];
    end
  end

  assign noise_o = noise_q;

endmodule
`default_nettype wire

// File: rtl/vnts_shade.sv
`default_nettype none
// Octave mix, brightness, seam darkening and color channels.
module vnts_shade #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire vnts_pkg::vnts_cfg_t  cfg_i,
  input  wire logic [23:0]          n0_i,
  input  wire logic [23:0]          n1_i,
  input  wire logic [FRAC_BITS-1:0] cu_i,
  input  wire logic [FRAC_BITS-1:0] cv_i,
  output vnts_pkg::vnts_pix_t       pix_o
);

  localparam int unsigned SW = FRAC_BITS + 17;

  function automatic logic near_seam(input logic [FRAC_BITS-1:0] f,
                                     input logic [15:0] lw);
    logic [FRAC_BITS:0] fe, cf, d;
    fe = {1'b0, f};
    cf = ((FRAC_BITS+1)'(1) << FRAC_BITS) - fe;
    d  = (fe <= cf) ? fe : cf;
    return SW'({d, 16'b0}) < SW'({lw, {FRAC_BITS{1'b0}}});
  endfunction

  function automatic logic [7:0] chan(input logic [36:0] p, input logic pos);
    logic [36:0] r;
    r = p + 37'(1 << 23);
    if (!pos) begin
      return 8'd0;
    end else if (p >= (37'd255 << 24)) begin
      return 8'd255;
    end
    return r[31:24];
  endfunction

  // stage 1: octave mix and seam test
  logic [41:0] mix_s;
  logic [23:0] n_q;
  logic        seam1_q;

  assign mix_s = 42'(n0_i) * 42'(vnts_pkg::MIX_W0) + 42'(n1_i) * 42'(vnts_pkg::MIX_W1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q     <= mix_s[39:16];
      seam1_q <= (cfg_i.grid_spacing != 16'd0) &&
                 (near_seam(cu_i, cfg_i.grid_line_width) ||
                  near_seam(cv_i, cfg_i.grid_line_width));
    end
  end

  // stage 2: signed swing times strength
  logic signed [25:0] sn;
  logic signed [42:0] prod_q;
  logic               seam2_q;

  assign sn = $signed({1'b0, n_q, 1'b0}) - 26'sd16777216;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= 43'(sn) * 43'($signed({1'b0, cfg_i.noise_strength}));
      seam2_q <= seam1_q;
    end
  end

  // stage 3: brightness, division truncates toward zero
  logic signed [42:0] adj1, sh1;
  logic signed [27:0] b_q;
  logic               seam3_q;

  assign adj1 = prod_q[42] ? prod_q + 43'sd16383 : prod_q;
  assign sh1  = adj1 >>> 14;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q     <= sh1[27:0] + 28'sd16777216;
      seam3_q <= seam2_q;
    end
  end

  // stage 4: seam factor, unity when off the seam
  logic        [15:0] fac;
  logic signed [44:0] prod2_q;
  logic               seam4_q;

  assign fac = seam3_q ? cfg_i.grid_darken : 16'h8000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod2_q <= 45'(b_q) * 45'($signed({1'b0, fac}));
      seam4_q <= seam3_q;
    end
  end

  // stage 5
  logic signed [44:0] adj2, sh2;
  logic signed [29:0] b2_q;
  logic               seam5_q;

  assign adj2 = prod2_q[44] ? prod2_q + 45'sd32767 : prod2_q;
  assign sh2  = adj2 >>> 15;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b2_q    <= sh2[29:0];
      seam5_q <= seam4_q;
    end
  end

  // stage 6: channel products
  logic [36:0] pr_q, pg_q, pb_q;
  logic        pos_q, seam6_q;
  logic [36:0] mag;

  assign mag = 37'(b2_q[28:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q    <= 37'(cfg_i.base_color[23:16]) * mag;
      pg_q    <= 37'(cfg_i.base_color[15:8]) * mag;
      pb_q    <= 37'(cfg_i.base_color[7:0]) * mag;
      pos_q   <= !b2_q[29] && (b2_q != 30'sd0);
      seam6_q <= seam5_q;
    end
  end

  assign pix_o.red     = chan(pr_q, pos_q);
  assign pix_o.green   = chan(pg_q, pos_q);
  assign pix_o.blue    = chan(pb_q, pos_q);
  assign pix_o.on_seam = seam6_q;

endmodule
`default_nettype wire

// File: rtl/value_noise_texture_shader.sv
`default_nettype none
// Value-noise texture shader. A request on the input channel carries one
// pixel (pixel_x_i, pixel_y_i); one request on the output channel returns
// its RGBA color and a seam flag. Both channels are valid/ready.
// Throughput: one pixel per clock, sustained while the skid register is not
// full. The pipeline is the bit-per-stage divider that maps the pixel center
// to u,v, followed by two pipeline stages of coordinate scaling, the 6-stage
// octave units and the 6-stage shading unit, then the output register.
// Registers are written on the cfg channel (always ready); the user must
// write them only while the block is idle, which the block does not enforce.
// They hold their reset defaults until written.
// Reset clears all valid bits and loads the register defaults; no pixel is
// in flight afterwards and no memory needs clearing.
// When the receiver stalls, the output register holds its result and one
// further result lands in a skid register; input ready drops only while the
// skid register is full, and the whole pipeline then holds in place.
module value_noise_texture_shader #(
  parameter int unsigned MAX_DIM   = vnts_pkg::MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = vnts_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [11:0] pixel_x_i,
  input  wire logic [11:0] pixel_y_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       alpha_o,
  output logic             on_seam_o
);

  localparam int unsigned DVW  = 12 + FRAC_BITS;
  localparam int unsigned DIMW = $clog2(MAX_DIM + 1);
  localparam int unsigned PW   = DVW + 16;
  localparam int unsigned X1W  = DVW + 8;
  localparam int unsigned P2W  = X1W + 18;
  localparam int unsigned X2W  = X1W + 2;
  localparam int unsigned LAT  = DVW + 2 + vnts_pkg::OCT_LAT + vnts_pkg::SHADE_LAT;
  // cell fraction waits through stage B and the octave units
  localparam int unsigned CUD  = vnts_pkg::OCT_LAT + 2;

  function automatic logic [DIMW-1:0] read_dim(input logic [12:0] d);
    if (d == 13'd0) begin
      return DIMW'(1);
    end else if ({1'b0, d} > 14'(MAX_DIM)) begin
      return DIMW'(MAX_DIM);
    end
    return DIMW'(d);
  endfunction

  // configuration registers
  vnts_pkg::vnts_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_scale     <= 16'd2048;
      cfg_q.seed            <= 32'd0;
      cfg_q.noise_strength  <= 16'd4096;
      cfg_q.grid_spacing    <= 16'd0;
      cfg_q.grid_line_width <= 16'd1311;
      cfg_q.grid_darken     <= 16'd19661;
      cfg_q.base_color      <= 24'h808080;
      cfg_q.image_dims      <= 26'd524352;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vnts_pkg::CFG_NOISE_SCALE:     cfg_q.noise_scale     <= cfg_data_i[15:0];
        vnts_pkg::CFG_SEED:            cfg_q.seed            <= cfg_data_i;
        vnts_pkg::CFG_NOISE_STRENGTH:  cfg_q.noise_strength  <= cfg_data_i[15:0];
        vnts_pkg::CFG_GRID_SPACING:    cfg_q.grid_spacing    <= cfg_data_i[15:0];
        vnts_pkg::CFG_GRID_LINE_WIDTH: cfg_q.grid_line_width <= cfg_data_i[15:0];
        vnts_pkg::CFG_GRID_DARKEN:     cfg_q.grid_darken     <= cfg_data_i[15:0];
        vnts_pkg::CFG_BASE_COLOR:      cfg_q.base_color      <= cfg_data_i[23:0];
        vnts_pkg::CFG_IMAGE_DIMS:      cfg_q.image_dims      <= cfg_data_i[25:0];
      endcase
    end
  end

  // pipeline control
  logic            en;
  logic [LAT-1:0]  vld_q;
  logic            skid_vld_q, skid_vld_d;
  logic            out_vld_q, out_vld_d;

  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // u,v = pixel center over dimension
  logic [DVW-1:0] divx, divy, u, v;

  assign divx = DVW'({pixel_x_i, 1'b1}) << (FRAC_BITS - 1);
  assign divy = DVW'({pixel_y_i, 1'b1}) << (FRAC_BITS - 1);

  vnts_div #(.DVW(DVW), .DIMW(DIMW)) u_div_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (divx),
    .divisor_i  (read_dim(cfg_q.image_dims[12:0])),
    .quotient_o (u)
  );

  vnts_div #(.DVW(DVW), .DIMW(DIMW)) u_div_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (divy),
    .divisor_i  (read_dim(cfg_q.image_dims[25:13])),
    .quotient_o (v)
  );

  // stage A: octave-1 and cell coordinates
  logic [PW-1:0]        xu_p, yv_p, cu_p, cv_p;
  logic [X1W-1:0]       x1_q, y1_q;
  logic [FRAC_BITS-1:0] cud_q [CUD];
  logic [FRAC_BITS-1:0] cvd_q [CUD];

  assign xu_p = PW'(u) * PW'(cfg_q.noise_scale);
  assign yv_p = PW'(v) * PW'(cfg_q.noise_scale);
  assign cu_p = PW'(u) * PW'(cfg_q.grid_spacing);
  assign cv_p = PW'(v) * PW'(cfg_q.grid_spacing);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q     <= xu_p[PW-1:8];
      y1_q     <= yv_p[PW-1:8];
      cud_q[0] <= cu_p[8 +: FRAC_BITS];
      cvd_q[0] <= cv_p[8 +: FRAC_BITS];
      for (int i = 1; i < CUD; i++) begin
        cud_q[i] <= cud_q[i-1];
        cvd_q[i] <= cvd_q[i-1];
      end
    end
  end

  // stage B: octave-2 coordinates at 2.7x
  logic [P2W-1:0] x2_p, y2_p;
  logic [X2W-1:0] x2_q, y2_q;
  logic [X1W-1:0] x1d_q, y1d_q;

  assign x2_p = P2W'(x1_q) * P2W'(vnts_pkg::OCT2_MUL);
  assign y2_p = P2W'(y1_q) * P2W'(vnts_pkg::OCT2_MUL);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q  <= x2_p[P2W-1:16];
      y2_q  <= y2_p[P2W-1:16];
      x1d_q <= x1_q;
      y1d_q <= y1_q;
    end
  end

  logic [23:0] n0, n1;

  vnts_oct #(.XW(X1W), .FRAC_BITS(FRAC_BITS)) u_oct0 (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (x1d_q),
    .y_i     (y1d_q),
    .seed_i  (cfg_q.seed),
    .noise_o (n0)
  );

  vnts_oct #(.XW(X2W), .FRAC_BITS(FRAC_BITS)) u_oct1 (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (x2_q),
    .y_i     (y2_q),
    .seed_i  (cfg_q.seed + 32'd1),
    .noise_o (n1)
  );

  vnts_pkg::vnts_pix_t pix, out_q, skid_q;

  vnts_shade #(.FRAC_BITS(FRAC_BITS)) u_shade (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg_q),
    .n0_i  (n0),
    .n1_i  (n1),
    .cu_i  (cud_q[CUD-1]),
    .cv_i  (cvd_q[CUD-1]),
    .pix_o (pix)
  );

  // output register plus one skid entry
  logic load_out, load_skid, pop_skid;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    pop_skid   = 1'b0;
    if (en && vld_q[LAT-1]) begin
      if (!out_vld_q || out_ready_i) begin
        load_out  = 1'b1;
        out_vld_d = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_vld_d = 1'b1;
      end
    end else if (skid_vld_q && out_ready_i) begin
      pop_skid   = 1'b1;
      skid_vld_d = 1'b0;
      out_vld_d  = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= pix;
    end else if (pop_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= pix;
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_o       = out_q.red;
  assign green_o     = out_q.green;
  assign blue_o      = out_q.blue;
  assign alpha_o     = 8'd255;
  assign on_seam_o   = out_q.on_seam;

endmodule
`default_nettype wire

// File: tb/value_noise_texture_shader_chk.sv
module value_noise_texture_shader_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  input  logic        on_seam_i,
  output int          errors_o,
  output int          pending_o
);
  import vnts_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;

  vnts_cfg_t regs;
  vnts_pix_t color_q[$];

  function automatic logic [23:0] corner_hash(logic [31:0] ix, logic [31:0] iy,
                                              logic [31:0] sd);
    logic [31:0] h;
    h = ix * HASH_KX + iy * HASH_KY + sd * HASH_KS + HASH_OFF;
    h = (h ^ (h >> 13)) * HASH_MIX;
    h = h ^ (h >> 16);
    return h[23:0];
  endfunction

  function automatic logic [63:0] fade(logic [63:0] c);
    logic [63:0] t;
    t = (c & ((64'd1 << FB) - 1)) >> (FB - 16);
    return (t * t * (64'd196608 - 2 * t)) >> 32;
  endfunction

  function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * (64'd65536 - s) + b * s) >> 16;
  endfunction

  function automatic logic [63:0] noise_octave(logic [63:0] x, logic [63:0] y,
                                               logic [31:0] sd);
    logic [31:0] x0, y0;
    logic [63:0] sx, sy, top, bot;
    x0 = x[FB +: 32];
    y0 = y[FB +: 32];
    sx = fade(x);
    sy = fade(y);
    top = blend(corner_hash(x0, y0, sd), corner_hash(x0 + 1, y0, sd), sx);
    bot = blend(corner_hash(x0, y0 + 1, sd), corner_hash(x0 + 1, y0 + 1, sd), sx);
    return blend(top, bot, sy);
  endfunction

  function automatic bit near_line(logic [63:0] c);
    logic [63:0] f, d;
    f = c & ((64'd1 << FB) - 1);
    d = (f <= (64'd1 << FB) - f) ? f : (64'd1 << FB) - f;
    return (d << 16) < (64'(regs.grid_line_width) << FB);
  endfunction

  function automatic logic [63:0] clamp_dim(logic [12:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return d;
  endfunction

  function automatic logic [7:0] scale_chan(logic [7:0] c, longint b);
    longint p;
    if (b <= 0) return 0;
    p = longint'(c) * b;
    if (p >= (longint'(255) << 24)) return 255;
    return 8'((p + (longint'(1) << 23)) >>> 24);
  endfunction

  function automatic vnts_pix_t shade_pixel(logic [11:0] px, logic [11:0] py);
    vnts_pix_t r;
    logic [63:0] w, h, u, v, x1, y1, x2, y2, n0, n1, n;
    longint b;
    w = clamp_dim(regs.image_dims[12:0]);
    h = clamp_dim(regs.image_dims[25:13]);
    u = ((2 * 64'(px) + 1) << (FB - 1)) / w;
    v = ((2 * 64'(py) + 1) << (FB - 1)) / h;
    x1 = (u * regs.noise_scale) >> 8;
    y1 = (v * regs.noise_scale) >> 8;
    x2 = (x1 * OCT2_MUL) >> 16;
    y2 = (y1 * OCT2_MUL) >> 16;
    n0 = noise_octave(x1, y1, regs.seed);
    n1 = noise_octave(x2, y2, regs.seed + 32'd1);
    n = (n0 * MIX_W0 + n1 * MIX_W1) >> 16;
    b = (longint'(1) << 24) +
        ((longint'(2 * n) - (longint'(1) << 24)) * longint'(regs.noise_strength)) / 16384;
    r.on_seam = 1'b0;
    if (regs.grid_spacing != 0) begin
      r.on_seam = near_line((u * regs.grid_spacing) >> 8) ||
                  near_line((v * regs.grid_spacing) >> 8);
      if (r.on_seam) b = (b * longint'(regs.grid_darken)) / 32768;
    end
    r.red = scale_chan(regs.base_color[23:16], b);
    r.green = scale_chan(regs.base_color[15:8], b);
    r.blue = scale_chan(regs.base_color[7:0], b);
    return r;
  endfunction

  assign pending_o = color_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    vnts_pix_t exp_c;
    if (!rst_ni) begin
      regs.noise_scale <= 16'd2048;
      regs.seed <= '0;
      regs.noise_strength <= 16'd4096;
      regs.grid_spacing <= '0;
      regs.grid_line_width <= 16'd1311;
      regs.grid_darken <= 16'd19661;
      regs.base_color <= 24'h808080;
      regs.image_dims <= 26'd524352;
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) color_q.push_back(shade_pixel(pixel_x_i, pixel_y_i));
      if (out_valid_i && out_ready_i) begin
        if (color_q.size() == 0) begin
          $display("%0t: unexpected pixel result r=%0d g=%0d b=%0d", $time,
                   red_i, green_i, blue_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_c = color_q.pop_front();
          if (red_i !== exp_c.red || green_i !== exp_c.green || blue_i !== exp_c.blue ||
              alpha_i !== 8'd255 || on_seam_i !== exp_c.on_seam) begin
            $display("%0t: pixel mismatch exp r=%0d g=%0d b=%0d a=255 seam=%0d", $time,
                     exp_c.red, exp_c.green, exp_c.blue, exp_c.on_seam);
            $display("%0t:                got r=%0d g=%0d b=%0d a=%0d seam=%0d", $time,
                     red_i, green_i, blue_i, alpha_i, on_seam_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_NOISE_SCALE:     regs.noise_scale <= cfg_data_i[15:0];
          CFG_SEED:            regs.seed <= cfg_data_i;
          CFG_NOISE_STRENGTH:  regs.noise_strength <= cfg_data_i[15:0];
          CFG_GRID_SPACING:    regs.grid_spacing <= cfg_data_i[15:0];
          CFG_GRID_LINE_WIDTH: regs.grid_line_width <= cfg_data_i[15:0];
          CFG_GRID_DARKEN:     regs.grid_darken <= cfg_data_i[15:0];
          CFG_BASE_COLOR:      regs.base_color <= cfg_data_i[23:0];
          CFG_IMAGE_DIMS:      regs.image_dims <= cfg_data_i[25:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// File: tb/value_noise_texture_shader_tb.sv
module value_noise_texture_shader_tb;
  import vnts_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [11:0] pixel_x_i = '0;
  logic [11:0] pixel_y_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  red_o, green_o, blue_o, alpha_o;
  logic        on_seam_o;
  int          errors;
  int          pending;
  int          cycle_cnt = 0;
  bit          calm = 1'b0;

  value_noise_texture_shader u_top (.*);

  value_noise_texture_shader_chk u_chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .pixel_x_i, .pixel_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .red_i(red_o), .green_i(green_o),
    .blue_i(blue_o), .alpha_i(alpha_o), .on_seam_i(on_seam_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [11:0] x, logic [11:0] y);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i <= x;
    pixel_y_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_regs;
    reg_write(CFG_NOISE_SCALE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096));
    reg_write(CFG_SEED, $urandom);
    reg_write(CFG_NOISE_STRENGTH, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20000));
    reg_write(CFG_GRID_SPACING, $urandom_range(0, 2) == 0 ? 0 : $urandom);
    reg_write(CFG_GRID_LINE_WIDTH, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000));
    reg_write(CFG_GRID_DARKEN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32768));
    reg_write(CFG_BASE_COLOR, $urandom);
    // mostly small images, some zero or oversized sides
    case ($urandom_range(0, 3))
      0: reg_write(CFG_IMAGE_DIMS, $urandom);
      1: reg_write(CFG_IMAGE_DIMS, {$urandom_range(0, 1) ? 13'd0 : 13'h1fff,
                                    13'($urandom_range(0, 8191))});
      default: reg_write(CFG_IMAGE_DIMS, {13'($urandom_range(1, 256)),
                                          13'($urandom_range(1, 256))});
    endcase
  endtask

  initial begin
    logic [11:0] edge_v[4];
    edge_v = '{12'd0, 12'd1, 12'd2048, 12'd4095};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset settings, field extremes
    foreach (edge_v[i]) foreach (edge_v[j]) send_pixel(edge_v[i], edge_v[j]);
    drain();
    // extreme settings: seams on, darken above one, full color, zero/oversized dims
    reg_write(CFG_NOISE_SCALE, 32'hffff);
    reg_write(CFG_SEED, 32'hffffffff);
    reg_write(CFG_NOISE_STRENGTH, 32'hffff);
    reg_write(CFG_GRID_SPACING, 32'hffff);
    reg_write(CFG_GRID_LINE_WIDTH, 32'hffff);
    reg_write(CFG_GRID_DARKEN, 32'hffff);
    reg_write(CFG_BASE_COLOR, 32'hffffff);
    reg_write(CFG_IMAGE_DIMS, {13'h1fff, 13'd0});
    foreach (edge_v[i]) send_pixel(edge_v[i], edge_v[3 - i]);
    drain();
    reg_write(CFG_NOISE_SCALE, 0);
    reg_write(CFG_NOISE_STRENGTH, 0);
    reg_write(CFG_GRID_LINE_WIDTH, 0);
    reg_write(CFG_GRID_DARKEN, 0);
    reg_write(CFG_BASE_COLOR, 0);
    reg_write(CFG_IMAGE_DIMS, 32'h3ffffff);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    drain();
    for (int ph = 0; ph < 14; ph++) begin
      random_regs();
      if (ph == 12) calm = 1'b1;
      repeat (100) send_pixel($urandom, $urandom);
      drain();
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
